/* rtl/cweq_pkg.sv */
// Package for the coalescing window event queue.
// It holds the table geometry, the command codes, the flag bits and the table entry type.
// It depends on nothing else.
package cweq_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_RECT   = 2'd0;
  localparam logic [1:0] CMD_NOTIFY = 2'd1;
  localparam logic [1:0] CMD_DRAIN  = 2'd2;

  localparam int FL_CFG  = 0;
  localparam int FL_EXP  = 1;
  localparam int FL_RECT = 2;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic [31:0] wid;
    logic [2:0]  flags;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] cnt;
  } entry_t;

endpackage

/* rtl/coalescing_window_event_queue_core.sv */
// Top level of the coalescing window event queue.
// It holds the entry table memory, the lookup and merge sequencer and the drain sequencer.
// It depends on cweq_pkg.
//
// Usage: an item is taken when start is high and busy is low. Commands 0 (rectangle
// expose) and 1 (flag notify) look up the window id by reading the table slot by slot
// (memory read, then compare) from the oldest entry, and then write the merged or
// appended entry back; a new window is dropped when the table is full. Ignored items
// leave the block idle.
// A drain (command 2) emits up to in_drain_max of the oldest entries, one by one, each
// read and then registered; out_valid marks each result for exactly one cycle and
// out_last marks the final one. A drain with nothing to send gives one empty result
// in the cycle after it is taken.
// The receiver cannot stall; results are simply shown for one cycle.
// Reset empties the table (head and occupancy to zero); memory contents are not
// cleared, since only occupied slots are ever compared or emitted.
module coalescing_window_event_queue_core
  import cweq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_window_id,
  input  logic [15:0] in_rect_x,
  input  logic [15:0] in_rect_y,
  input  logic [15:0] in_rect_w,
  input  logic [15:0] in_rect_h,
  input  logic [15:0] in_expose_count,
  input  logic        in_want_configure,
  input  logic        in_want_expose,
  input  logic [5:0]  in_drain_max,
  output logic        out_valid,
  output logic        out_entry_valid,
  output logic [31:0] out_window_id,
  output logic        out_configure_pending,
  output logic        out_expose_pending,
  output logic        out_has_rect,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [15:0] out_w,
  output logic [15:0] out_h,
  output logic [15:0] out_count,
  output logic        out_last
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SRD  = 6'b000010,
    ST_SCMP = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_DRD  = 6'b010000,
    ST_DOUT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [OCC_W-1:0]  k_r, k_nxt;
  logic [OCC_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic              found_r, found_nxt;
  entry_t            base_r, base_nxt;

  // Latched item.
  logic [1:0]  cmd_r;
  logic [31:0] wid_r;
  logic [15:0] rx_r, ry_r, rw_r, rh_r, cnt_r;
  logic        wc_r, we_r;

  // Entry table.
  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_r;
  logic [IDX_W-1:0]  raddr;
  logic              wr_en;
  entry_t            wr_data;

  // Result register.
  logic   ov_r, ov_nxt, olast_r, olast_nxt;
  entry_t oent_r, oent_nxt;
  logic   oev_r, oev_nxt;

  logic   accept, item_ok;
  logic [OCC_W-1:0] dn;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // An item is active when it names a window and carries something to record.
  always_comb begin
    item_ok = 1'b0;
    if (in_window_id != 32'd0) begin
      if (in_command == CMD_RECT) begin
        item_ok = (in_rect_w != 16'd0) && (in_rect_h != 16'd0);
      end else if (in_command == CMD_NOTIFY) begin
        item_ok = in_want_configure || in_want_expose;
      end
    end
    dn = (OCC_W'(in_drain_max) < occ_r) ? OCC_W'(in_drain_max) : occ_r;
  end

  // Read address follows the slot under inspection.
  assign raddr = head_r + k_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
    if (wr_en) begin
      mem[slot_r] <= wr_data;
    end
  end

  // Merge of the latched item into the base entry.
  logic [16:0] x1, y1, nx1, ny1, ux1, uy1, uw, uh;
  logic [15:0] ux0, uy0;
  entry_t      upd;
  always_comb begin
    upd     = found_r ? base_r : '0;
    upd.wid = wid_r;
    x1  = {1'b0, base_r.x} + {1'b0, base_r.w};
    y1  = {1'b0, base_r.y} + {1'b0, base_r.h};
    nx1 = {1'b0, rx_r} + {1'b0, rw_r};
    ny1 = {1'b0, ry_r} + {1'b0, rh_r};
    ux0 = (base_r.x < rx_r) ? base_r.x : rx_r;
    uy0 = (base_r.y < ry_r) ? base_r.y : ry_r;
    ux1 = (x1 > nx1) ? x1 : nx1;
    uy1 = (y1 > ny1) ? y1 : ny1;
    uw  = ux1 - {1'b0, ux0};
    uh  = uy1 - {1'b0, uy0};
    if (cmd_r == CMD_RECT) begin
      if (!found_r) begin
        upd.flags = 3'b0;
        upd.flags[FL_EXP]  = 1'b1;
        upd.flags[FL_RECT] = 1'b1;
        upd.x = rx_r; upd.y = ry_r; upd.w = rw_r; upd.h = rh_r;
        upd.cnt = cnt_r;
      end else begin
        upd.flags[FL_EXP] = 1'b1;
        if (base_r.flags[FL_RECT]) begin
          if (base_r.w == 16'd0 || base_r.h == 16'd0) begin
            upd.x = rx_r; upd.y = ry_r; upd.w = rw_r; upd.h = rh_r;
          end else begin
            upd.x = ux0;
            upd.y = uy0;
            upd.w = uw[16] ? SAT16 : uw[15:0];
            upd.h = uh[16] ? SAT16 : uh[15:0];
          end
          upd.cnt = cnt_r;
        end
      end
    end else begin
      if (wc_r) begin
        upd.flags[FL_CFG] = 1'b1;
      end
      if (we_r) begin
        upd.flags[FL_EXP]  = 1'b1;
        upd.flags[FL_RECT] = 1'b0;
        upd.x = '0; upd.y = '0; upd.w = '0; upd.h = '0;
        upd.cnt = '0;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    occ_nxt   = occ_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    slot_nxt  = slot_r;
    found_nxt = found_r;
    base_nxt  = base_r;
    wr_en     = 1'b0;
    wr_data   = upd;
    ov_nxt    = 1'b0;
    olast_nxt = 1'b0;
    oev_nxt   = 1'b0;
    oent_nxt  = oent_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          k_nxt = '0;
          if (in_command == CMD_DRAIN) begin
            if (dn == '0) begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              oent_nxt  = '0;
            end else begin
              n_nxt     = dn;
              state_nxt = ST_DRD;
            end
          end else if (item_ok) begin
            if (occ_r != '0) begin
              state_nxt = ST_SRD;
            end else begin
              found_nxt = 1'b0;
              slot_nxt  = head_r;
              occ_nxt   = occ_r + 1'b1;
              state_nxt = ST_UPD;
            end
          end
        end
      end
      ST_SRD: begin
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        if (rd_r.wid == wid_r) begin
          found_nxt = 1'b1;
          base_nxt  = rd_r;
          slot_nxt  = raddr;
          state_nxt = ST_UPD;
        end else if (k_r + 1'b1 == occ_r) begin
          found_nxt = 1'b0;
          slot_nxt  = head_r + occ_r[IDX_W-1:0];
          if (occ_r < OCC_W'(TABLE_DEPTH)) begin
            occ_nxt   = occ_r + 1'b1;
            state_nxt = ST_UPD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SRD;
        end
      end
      ST_UPD: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DRD: begin
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        ov_nxt    = 1'b1;
        oev_nxt   = 1'b1;
        oent_nxt  = rd_r;
        if (k_r + 1'b1 == n_r) begin
          olast_nxt = 1'b1;
          head_nxt  = head_r + n_r[IDX_W-1:0];
          occ_nxt   = occ_r - n_r;
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_DRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
      k_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    slot_r  <= slot_nxt;
    found_r <= found_nxt;
    base_r  <= base_nxt;
    olast_r <= olast_nxt;
    oev_r   <= oev_nxt;
    oent_r  <= oent_nxt;
    if (accept) begin
      cmd_r <= in_command;
      wid_r <= in_window_id;
      rx_r  <= in_rect_x;
      ry_r  <= in_rect_y;
      rw_r  <= in_rect_w;
      rh_r  <= in_rect_h;
      cnt_r <= in_expose_count;
      wc_r  <= in_want_configure;
      we_r  <= in_want_expose;
    end
  end

  assign out_valid             = ov_r;
  assign out_entry_valid       = oev_r;
  assign out_window_id         = oent_r.wid;
  assign out_configure_pending = oent_r.flags[FL_CFG];
  assign out_expose_pending    = oent_r.flags[FL_EXP];
  assign out_has_rect          = oent_r.flags[FL_RECT];
  assign out_x                 = oent_r.x;
  assign out_y                 = oent_r.y;
  assign out_w                 = oent_r.w;
  assign out_h                 = oent_r.h;
  assign out_count             = oent_r.cnt;
  assign out_last              = olast_r;

  // The table never holds more entries than it has slots.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(TABLE_DEPTH))
    else $error("occupancy exceeds table depth");

  // A lookup read is always followed by its compare.
  a_srd_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRD |=> state_r == ST_SCMP)
    else $error("lookup read not followed by compare");

  // An empty result is always the final one of its drain.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_entry_valid) |-> out_last)
    else $error("empty result without last");

  // A drained entry follows a drain output step.
  a_drain_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |-> $past(state_r == ST_DOUT))
    else $error("entry result without drain step");

endmodule
